@@ rtl/trd_pkg.sv @@
// shared types and constants for the trace record deframer
// no dependencies; every other file takes names from here by scope

package trd_pkg;

  localparam int WORD_W      = 32;
  localparam int ID_W        = 28;
  localparam int CNT_W       = 3;
  localparam int TS_W        = 64;
  localparam int NUM_SLOTS   = 7;
  localparam int COUNT_LSB   = 28;
  localparam int TS_FLAG_BIT = 31;

  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 28;

  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ENABLE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WANTED_ID     = 1'b1;

  typedef enum logic [1:0] {
    K_HEADER,
    K_TS_LOW,
    K_TS_HIGH,
    K_DATA
  } kind_t;

  // one classified word travelling from front to back
  typedef struct packed {
    kind_t             kind;
    logic [CNT_W-1:0]  slot;
    logic              last;
    logic [WORD_W-1:0] word;
  } ent_t;

  typedef struct packed {
    logic            filter_enable;
    logic [ID_W-1:0] wanted_id;
  } cfg_t;

endpackage

@@ rtl/trd_ifs.sv @@
// valid/ready channel interfaces for trace words in and records out
// depends on trd_pkg

interface trd_in_if;
  logic                      valid;
  logic                      ready;
  logic [trd_pkg::WORD_W-1:0] word;

  modport source (output valid, output word, input ready);
  modport sink   (input valid, input word, output ready);
endinterface

interface trd_out_if;
  logic                       valid;
  logic                       ready;
  logic [trd_pkg::ID_W-1:0]   rec_id;
  logic [trd_pkg::CNT_W-1:0]  data_count;
  logic                       has_timestamp;
  logic [trd_pkg::TS_W-1:0]   timestamp;
  logic [trd_pkg::WORD_W-1:0] data_0;
  logic [trd_pkg::WORD_W-1:0] data_1;
  logic [trd_pkg::WORD_W-1:0] data_2;
  logic [trd_pkg::WORD_W-1:0] data_3;
  logic [trd_pkg::WORD_W-1:0] data_4;
  logic [trd_pkg::WORD_W-1:0] data_5;
  logic [trd_pkg::WORD_W-1:0] data_6;

  modport source (output valid, output rec_id, output data_count, output has_timestamp,
                  output timestamp, output data_0, output data_1, output data_2,
                  output data_3, output data_4, output data_5, output data_6,
                  input ready);
  modport sink   (input valid, input rec_id, input data_count, input has_timestamp,
                  input timestamp, input data_0, input data_1, input data_2,
                  input data_3, input data_4, input data_5, input data_6,
                  output ready);
endinterface

@@ rtl/trd_front.sv @@
// front end: tracks the record framing and tags each incoming word
// depends on trd_pkg and trd_in_if

module trd_front (
  input  logic             clk,
  input  logic             rst_n,
  trd_in_if.sink           in_chan,
  output logic             push_valid,
  input  logic             push_ready,
  output trd_pkg::ent_t    push_ent
);

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_TS_LOW,
    PH_TS_HIGH,
    PH_DATA
  } phase_t;

  phase_t                      phase_r, phase_nxt;
  logic [trd_pkg::CNT_W-1:0]   words_left_r, words_left_nxt;
  logic [trd_pkg::CNT_W-1:0]   count_r, count_nxt;
  logic                        push;
  logic [trd_pkg::CNT_W-1:0]   hdr_count;
  logic                        hdr_ts;

  assign in_chan.ready = push_ready;
  assign push_valid    = in_chan.valid;
  assign push          = in_chan.valid && push_ready;
  assign hdr_count     = in_chan.word[trd_pkg::COUNT_LSB +: trd_pkg::CNT_W];
  assign hdr_ts        = in_chan.word[trd_pkg::TS_FLAG_BIT];

  always_comb begin
    phase_nxt      = phase_r;
    words_left_nxt = words_left_r;
    count_nxt      = count_r;
    push_ent.word  = in_chan.word;
    push_ent.slot  = '0;
    push_ent.last  = 1'b0;
    push_ent.kind  = trd_pkg::K_HEADER;
    case (phase_r)
      PH_HEADER: begin
        push_ent.kind = trd_pkg::K_HEADER;
        count_nxt     = hdr_count;
        if (hdr_ts) begin
          phase_nxt = PH_TS_LOW;
        end else if (hdr_count != '0) begin
          phase_nxt      = PH_DATA;
          words_left_nxt = hdr_count;
        end else begin
          push_ent.last = 1'b1;
        end
      end
      PH_TS_LOW: begin
        push_ent.kind = trd_pkg::K_TS_LOW;
        phase_nxt     = PH_TS_HIGH;
      end
      PH_TS_HIGH: begin
        push_ent.kind = trd_pkg::K_TS_HIGH;
        if (count_r != '0) begin
          phase_nxt      = PH_DATA;
          words_left_nxt = count_r;
        end else begin
          phase_nxt     = PH_HEADER;
          push_ent.last = 1'b1;
        end
      end
      PH_DATA: begin
        push_ent.kind  = trd_pkg::K_DATA;
        push_ent.slot  = count_r - words_left_r;
        words_left_nxt = words_left_r - 1'b1;
        if (words_left_r == trd_pkg::CNT_W'(1)) begin
          phase_nxt     = PH_HEADER;
          push_ent.last = 1'b1;
        end
      end
      default: begin
        phase_nxt = PH_HEADER;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HEADER;
      words_left_r <= '0;
      count_r      <= '0;
    end else if (push) begin
      phase_r      <= phase_nxt;
      words_left_r <= words_left_nxt;
      count_r      <= count_nxt;
    end
  end

  // data phase always has at least one word outstanding
  a_data_left: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DATA |-> words_left_r != '0)
    else $error("data phase with no words left");

endmodule

@@ rtl/trd_queue.sv @@
// short fifo of classified words between front and back end
// depends on trd_pkg

module trd_queue #(
  parameter int DEPTH = trd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  trd_pkg::ent_t    push_ent,
  output logic             pop_valid,
  input  logic             pop_ready,
  output trd_pkg::ent_t    pop_ent
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  trd_pkg::ent_t   mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   count_r;
  logic            push, pop;

  assign push_ready = count_r != CW'(DEPTH);
  assign pop_valid  = count_r != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_ent    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      count_r <= count_r + CW'(push) - CW'(pop);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue fill above depth");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> count_r == $past(count_r) + CW'($past(push)) - CW'($past(pop)))
    else $error("queue fill out of step with transfers");

endmodule

@@ rtl/trd_back.sv @@
// back end: assembles records from tagged words, filters and holds the result
// depends on trd_pkg and trd_out_if

module trd_back (
  input  logic             clk,
  input  logic             rst_n,
  input  trd_pkg::cfg_t    cfg,
  input  logic             pop_valid,
  output logic             pop_ready,
  input  trd_pkg::ent_t    pop_ent,
  trd_out_if.source        out_chan
);

  logic [trd_pkg::ID_W-1:0]   id_r, id_nxt;
  logic [trd_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                       tsf_r, tsf_nxt;
  logic [trd_pkg::TS_W-1:0]   ts_r, ts_nxt;
  logic [trd_pkg::WORD_W-1:0] data_r [trd_pkg::NUM_SLOTS];
  logic [trd_pkg::WORD_W-1:0] data_nxt [trd_pkg::NUM_SLOTS];

  logic                       out_valid_r, out_valid_nxt;
  logic [trd_pkg::ID_W-1:0]   o_id_r;
  logic [trd_pkg::CNT_W-1:0]  o_cnt_r;
  logic                       o_tsf_r;
  logic [trd_pkg::TS_W-1:0]   o_ts_r;
  logic [trd_pkg::WORD_W-1:0] o_data_r [trd_pkg::NUM_SLOTS];

  logic pop, emit;

  assign pop_ready = !out_valid_r || out_chan.ready;
  assign pop       = pop_valid && pop_ready;

  always_comb begin
    id_nxt   = id_r;
    cnt_nxt  = cnt_r;
    tsf_nxt  = tsf_r;
    ts_nxt   = ts_r;
    data_nxt = data_r;
    if (pop) begin
      case (pop_ent.kind)
        trd_pkg::K_HEADER: begin
          id_nxt  = pop_ent.word[trd_pkg::ID_W-1:0];
          cnt_nxt = pop_ent.word[trd_pkg::COUNT_LSB +: trd_pkg::CNT_W];
          tsf_nxt = pop_ent.word[trd_pkg::TS_FLAG_BIT];
          ts_nxt  = '0;
          for (int k = 0; k < trd_pkg::NUM_SLOTS; k++) begin
            data_nxt[k] = '0;
          end
        end
        trd_pkg::K_TS_LOW: begin
          ts_nxt = {{(trd_pkg::TS_W - trd_pkg::WORD_W){1'b0}}, pop_ent.word};
        end
        trd_pkg::K_TS_HIGH: begin
          ts_nxt[trd_pkg::TS_W-1:trd_pkg::WORD_W] = pop_ent.word;
        end
        trd_pkg::K_DATA: begin
          if (pop_ent.slot < trd_pkg::CNT_W'(trd_pkg::NUM_SLOTS)) begin
            data_nxt[pop_ent.slot] = pop_ent.word;
          end
        end
        default: begin
          id_nxt = id_r;
        end
      endcase
    end
  end

  // filter uses the assembled id of the completing record
  assign emit = pop && pop_ent.last && (!cfg.filter_enable || id_nxt == cfg.wanted_id);

  always_comb begin
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r   <= id_nxt;
    cnt_r  <= cnt_nxt;
    tsf_r  <= tsf_nxt;
    ts_r   <= ts_nxt;
    data_r <= data_nxt;
    if (emit) begin
      o_id_r   <= id_nxt;
      o_cnt_r  <= cnt_nxt;
      o_tsf_r  <= tsf_nxt;
      o_ts_r   <= ts_nxt;
      o_data_r <= data_nxt;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.rec_id        = o_id_r;
  assign out_chan.data_count    = o_cnt_r;
  assign out_chan.has_timestamp = o_tsf_r;
  assign out_chan.timestamp     = o_ts_r;
  assign out_chan.data_0        = o_data_r[0];
  assign out_chan.data_1        = o_data_r[1];
  assign out_chan.data_2        = o_data_r[2];
  assign out_chan.data_3        = o_data_r[3];
  assign out_chan.data_4        = o_data_r[4];
  assign out_chan.data_5        = o_data_r[5];
  assign out_chan.data_6        = o_data_r[6];

  a_hdr_clears: assert property (@(posedge clk) disable iff (!rst_n)
    pop && pop_ent.kind == trd_pkg::K_HEADER |=> data_r[0] == '0 && ts_r == '0)
    else $error("header did not clear record store");

  a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(pop && pop_ent.last))
    else $error("result raised without a completing word");

endmodule

@@ rtl/trace_record_deframer.sv @@
// top level of the trace record deframer: config registers, front, queue, back
// depends on trd_pkg, trd_ifs, trd_front, trd_queue and trd_back
//
//   channel    dir  handshake            payload
//   in_chan    in   valid/ready          word (32)
//   out_chan   out  valid/ready          rec_id, data_count, has_timestamp,
//                                        timestamp, data_0 .. data_6
//   cfg_*      in   cfg_we, no ready     cfg_index (1), cfg_data (28)
//
// one trace word per cycle is taken while the queue has room; the front end only tags each word, so it
// never stalls on its own, and the back end retires one tagged word per cycle unless the output stalls
// out_chan.valid for a record rises after its last word has passed through the queue
// (the queue entry is written first, then the result register is loaded)
// a stalled output holds the result register; the queue then fills and
// in_chan.ready drops once it is full (QUEUE_DEPTH words of slack)
// rst_n is synchronous and clears framing state, queue pointers, config registers
// and the result valid; the record store is cleared by every header

module trace_record_deframer #(
  parameter int QUEUE_DEPTH = trd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  trd_in_if.sink                            in_chan,
  trd_out_if.source                         out_chan,
  input  logic                              cfg_we,
  input  logic [trd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [trd_pkg::CFG_DATA_W-1:0]    cfg_data
);

  trd_pkg::cfg_t cfg_r;
  trd_pkg::ent_t push_ent, pop_ent;
  logic          push_valid, push_ready;
  logic          pop_valid, pop_ready;

  // configuration writes; the user must do them only while the block is idle, the block does not enforce it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        trd_pkg::CFG_FILTER_ENABLE: cfg_r.filter_enable <= cfg_data[0];
        trd_pkg::CFG_WANTED_ID:     cfg_r.wanted_id     <= cfg_data[trd_pkg::ID_W-1:0];
        default:                    cfg_r               <= cfg_r;
      endcase
    end
  end

  // front end: framing tracker, tags each word with its role in the record
  trd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_ent   (push_ent)
  );

  // decoupling queue so front and back stall independently
  trd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_ent   (push_ent),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_ent    (pop_ent)
  );

  // back end: record assembly, filter and result register
  trd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_ent   (pop_ent),
    .out_chan  (out_chan)
  );

endmodule
